### rtl/core/rs4k_pkg.sv
// Shared types, constants and field arithmetic for the GF(4096) Reed-Solomon parity encoder.
`timescale 1ns / 1ps

package rs4k_pkg;

   // Code shape.
   localparam int PARITY_SYMBOLS = 315;
   localparam int SYMBOL_BITS    = 12;
   localparam int COUNT_BITS     = $clog2(PARITY_SYMBOLS);

   // Primitive polynomial x^12+x^7+x^4+x^3+1, including the x^12 term.
   localparam logic [SYMBOL_BITS:0] FIELD_POLY = 13'h1099;

   // Operation codes carried by an input beat.
   typedef enum logic [1:0] {
      ACT_DATA  = 2'd0,
      ACT_PAD   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef logic [SYMBOL_BITS-1:0] symbol_type;
   typedef logic [PARITY_SYMBOLS-1:0][SYMBOL_BITS-1:0] stage_array_type;
   typedef logic [PARITY_SYMBOLS:0][SYMBOL_BITS-1:0] gen_coef_type;

   // Input beat.
   typedef struct packed {
      logic [1:0]  action;
      symbol_type  symbol_in;
   } req_payload_type;

   // Result beat.
   typedef struct packed {
      symbol_type  symbol_out;
      logic        is_parity;
      logic        last_parity;
   } rsp_payload_type;

   // Operation handed from the top level to the parity register.
   typedef struct packed {
      logic        fire;
      logic [1:0]  action;
      symbol_type  symbol;
   } lfsr_op_type;

   // Multiplication in GF(2^12). With one constant operand this folds into an XOR matrix.
   function automatic symbol_type gf_mul(input symbol_type a, input symbol_type b);
      logic [SYMBOL_BITS:0] aa;
      symbol_type           acc;
      acc = '0;
      aa  = {1'b0, a};
      for (int i = 0; i < SYMBOL_BITS; i++) begin
         if (b[i]) begin
            acc = acc ^ aa[SYMBOL_BITS-1:0];
         end
         aa = aa << 1;
         if (aa[SYMBOL_BITS]) begin
            aa = aa ^ FIELD_POLY;
         end
      end
      return acc;
   endfunction

   // Generator polynomial with roots alpha^0 .. alpha^(PARITY_SYMBOLS-1), evaluated at
   // elaboration.
   function automatic gen_coef_type build_generator();
      gen_coef_type g;
      symbol_type   root;
      g    = '0;
      g[0] = symbol_type'(1);
      root = symbol_type'(1);
      for (int i = 0; i < PARITY_SYMBOLS; i++) begin
         for (int j = i + 1; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
         root = gf_mul(root, symbol_type'(2));
      end
      return g;
   endfunction

   localparam gen_coef_type GEN_COEF = build_generator();

endpackage

### rtl/core/rs4k_parity_lfsr.sv
// Parity feedback shift register: feeds symbols, shifts parity out and clears.
`timescale 1ns / 1ps

module rs4k_parity_lfsr (
   input  logic                  clock,
   input  logic                  reset,
   input  rs4k_pkg::lfsr_op_type op,
   output rs4k_pkg::symbol_type  low_stage
);

   rs4k_pkg::stage_array_type stage_ff;
   rs4k_pkg::stage_array_type stage_in;
   rs4k_pkg::symbol_type      feedback;

   // Feedback term: incoming symbol (zero for a pad step) plus the top stage.
   always_comb begin
      if (op.action == rs4k_pkg::ACT_DATA) begin
         feedback = op.symbol ^ stage_ff[rs4k_pkg::PARITY_SYMBOLS-1];
      end else begin
         feedback = stage_ff[rs4k_pkg::PARITY_SYMBOLS-1];
      end
   end

   // Next value of every stage, each one independent of the others.
   always_comb begin
      for (int j = 0; j < rs4k_pkg::PARITY_SYMBOLS; j++) begin
         unique case (op.action) inside
            rs4k_pkg::ACT_DATA, rs4k_pkg::ACT_PAD: begin
               if (j == 0) begin
                  stage_in[j] = rs4k_pkg::gf_mul(rs4k_pkg::GEN_COEF[j], feedback);
               end else begin
                  stage_in[j] = stage_ff[j-1] ^
                                rs4k_pkg::gf_mul(rs4k_pkg::GEN_COEF[j], feedback);
               end
            end
            rs4k_pkg::ACT_READ: begin
               if (j == rs4k_pkg::PARITY_SYMBOLS - 1) begin
                  stage_in[j] = '0;
               end else begin
                  stage_in[j] = stage_ff[j+1];
               end
            end
            default: begin
               stage_in[j] = '0;
            end
         endcase
      end
   end

   // Stages update only when an operation is executed.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (op.fire) begin
         stage_ff <= stage_in;
      end
   end

   assign low_stage = stage_ff[0];

endmodule

### rtl/core/rs_gf4096_parity_encoder_top.sv
// Top level of the GF(4096) Reed-Solomon systematic parity encoder.
`timescale 1ns / 1ps
//
//   Channel   Ports                      Direction   Beat contents
//   request   req_valid/ready/payload    in          action, symbol_in
//   response  rsp_valid/ready/payload    out         symbol_out, is_parity, last_parity
//
// One beat per cycle is sustained while the response side accepts results. A beat is held
// in the input register; when it executes, the 315-stage register updates through constant
// GF multipliers while any result lands in the output register. Pad and clear beats give no
// result. Synchronous reset zeroes all stages and the readout count at once. When the
// response side stalls, the output register holds and the input register fills,
// after which req_ready drops.

module rs_gf4096_parity_encoder_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rs4k_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rs4k_pkg::rsp_payload_type rsp_payload
);

   logic                              in_valid_ff;
   rs4k_pkg::req_payload_type         in_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   rs4k_pkg::rsp_payload_type         out_ff;
   rs4k_pkg::rsp_payload_type         out_in;
   logic [rs4k_pkg::COUNT_BITS-1:0]   count_ff;
   logic [rs4k_pkg::COUNT_BITS-1:0]   count_in;
   logic                              out_free;
   logic                              execute;
   logic                              is_last;
   rs4k_pkg::lfsr_op_type             op;
   rs4k_pkg::symbol_type              low_stage;

   // Handshake: the held beat executes when the output register can take a result.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign execute   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || execute;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
   end

   // Operation for the parity register.
   assign op.fire   = execute;
   assign op.action = in_ff.action;
   assign op.symbol = in_ff.symbol_in;

   rs4k_parity_lfsr u_lfsr (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .low_stage (low_stage)
   );

   // Result and readout count for the executing beat.
   assign is_last = (count_ff == rs4k_pkg::COUNT_BITS'(rs4k_pkg::PARITY_SYMBOLS - 1));

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      count_in     = count_ff;
      if (execute) begin
         unique case (in_ff.action)
            rs4k_pkg::ACT_DATA: begin
               out_valid_in       = 1'b1;
               out_in.symbol_out  = in_ff.symbol_in;
               out_in.is_parity   = 1'b0;
               out_in.last_parity = 1'b0;
            end
            rs4k_pkg::ACT_READ: begin
               out_valid_in       = 1'b1;
               out_in.symbol_out  = low_stage;
               out_in.is_parity   = 1'b1;
               out_in.last_parity = is_last;
               count_in           = is_last ? '0 : count_ff + 1'b1;
            end
            rs4k_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Output register and readout count.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

### rtl/core/rs4k_checker.sv
// Port-level checks for the parity encoder, bound to its top level.
`timescale 1ns / 1ps

module rs4k_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input rs4k_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rs4k_pkg::rsp_payload_type rsp_payload
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // Only a parity symbol can be flagged as the last one.
   a_last_is_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_parity |-> rsp_payload.is_parity)
      else $error("last_parity set on a data echo");

   // Reset empties the output side.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Reset leaves the block ready for a beat.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready right after reset");

endmodule

bind rs_gf4096_parity_encoder_top rs4k_checker u_rs4k_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/tb.sv
// Self-checking testbench for the GF(4096) Reed-Solomon parity encoder top level.
`timescale 1ns / 1ps

module tb;
   import rs4k_pkg::*;

   localparam int ITEM_TARGET = 850;
   localparam int QUIET_FROM  = 700;
   localparam int FIELD_ORDER = 4095;

   // Tracks the parity register and the result beats it should produce.
   class rs_parity_tracker;
      int unsigned     gf_exp[FIELD_ORDER];
      int unsigned     gf_log[FIELD_ORDER+1];
      symbol_type      gen_taps[PARITY_SYMBOLS+1];
      symbol_type      stage[PARITY_SYMBOLS];
      int unsigned     readout_pos;
      rsp_payload_type awaited_q[$];
      int unsigned     fail_count;
      int unsigned     checked_count;
      int unsigned     closing_seen;
      int unsigned     action_seen[4];

      function new();
         int unsigned x;
         symbol_type  root;
         // Power and logarithm tables of the field, alpha = 2.
         x = 1;
         for (int i = 0; i < FIELD_ORDER; i++) begin
            gf_exp[i] = x;
            gf_log[x] = i;
            x = x << 1;
            if (x & 32'h1000) begin
               x = x ^ FIELD_POLY;
            end
         end
         // Multiply out the product of (x + alpha^i) for every root.
         foreach (gen_taps[j]) gen_taps[j] = '0;
         gen_taps[0] = symbol_type'(1);
         for (int i = 0; i < PARITY_SYMBOLS; i++) begin
            root = symbol_type'(gf_exp[i]);
            for (int j = i + 1; j > 0; j--) begin
               gen_taps[j] = gen_taps[j-1] ^ gf_times(gen_taps[j], root);
            end
            gen_taps[0] = gf_times(gen_taps[0], root);
         end
         clear_stages();
         fail_count    = 0;
         checked_count = 0;
         closing_seen  = 0;
         foreach (action_seen[k]) action_seen[k] = 0;
      endfunction

      function symbol_type gf_times(symbol_type a, symbol_type b);
         if (a == 0 || b == 0) begin
            return '0;
         end
         return symbol_type'(gf_exp[(gf_log[a] + gf_log[b]) % FIELD_ORDER]);
      endfunction

      function void clear_stages();
         foreach (stage[j]) stage[j] = '0;
         readout_pos = 0;
      endfunction

      // One step of the division register with the given incoming symbol.
      function void shift_in(symbol_type sym);
         symbol_type fb;
         fb = sym ^ stage[PARITY_SYMBOLS-1];
         for (int j = PARITY_SYMBOLS - 1; j > 0; j--) begin
            stage[j] = stage[j-1] ^ gf_times(gen_taps[j], fb);
         end
         stage[0] = gf_times(gen_taps[0], fb);
      endfunction

      // Applies an accepted input beat and queues any result it causes.
      function void absorb_beat(req_payload_type p);
         rsp_payload_type r;
         logic            at_end;
         action_seen[p.action]++;
         case (action_type'(p.action))
            ACT_DATA: begin
               shift_in(p.symbol_in);
               r.symbol_out  = p.symbol_in;
               r.is_parity   = 1'b0;
               r.last_parity = 1'b0;
               awaited_q.push_back(r);
            end
            ACT_PAD: begin
               shift_in('0);
            end
            ACT_READ: begin
               at_end        = (readout_pos == PARITY_SYMBOLS - 1);
               r.symbol_out  = stage[0];
               r.is_parity   = 1'b1;
               r.last_parity = at_end;
               for (int j = 0; j < PARITY_SYMBOLS - 1; j++) begin
                  stage[j] = stage[j+1];
               end
               stage[PARITY_SYMBOLS-1] = '0;
               readout_pos = at_end ? 0 : readout_pos + 1;
               awaited_q.push_back(r);
            end
            default: begin
               clear_stages();
            end
         endcase
      endfunction

      // Compares a delivered result beat with the oldest outstanding one.
      function void compare_result(rsp_payload_type got);
         rsp_payload_type want;
         checked_count++;
         if (got.last_parity === 1'b1) begin
            closing_seen++;
         end
         if (awaited_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("[%0t] result with nothing outstanding: sym=%h par=%b last=%b",
                        $realtime, got.symbol_out, got.is_parity, got.last_parity);
            end
            return;
         end
         want = awaited_q.pop_front();
         if (got.symbol_out !== want.symbol_out || got.is_parity !== want.is_parity ||
             got.last_parity !== want.last_parity) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("[%0t] result %0d exp sym=%h par=%b last=%b got sym=%h par=%b last=%b",
                        $realtime, checked_count,
                        want.symbol_out, want.is_parity, want.last_parity,
                        got.symbol_out, got.is_parity, got.last_parity);
            end
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   rs_parity_tracker tracker = new();
   int unsigned      beats_sent = 0;
   bit               quiet_tail = 1'b0;

   rs_gf4096_parity_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", tracker.awaited_q.size());
      $display("TB_ERROR");
      $finish;
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.compare_result(rsp_payload);
      end
   end

   // Receiver: random stall bursts, one long hold to back the block up, none at the end.
   initial begin : rsp_side
      int unsigned hold_left;
      bit          long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_ready      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && tracker.checked_count >= 200) begin
            long_hold_done = 1'b1;
            hold_left      = 80;
         end else if (hold_left == 0 && !quiet_tail && $urandom_range(0, 6) == 0) begin
            hold_left = $urandom_range(1, 7);
         end
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = 1'b1;
         end
         @(negedge clock);
      end
   end

   function automatic symbol_type pick_symbol();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return symbol_type'($urandom_range(0, 4095));
      endcase
   endfunction

   // Offers one input beat, called at a falling edge, returns at the falling edge after it is taken.
   task automatic offer_beat(input action_type act, input symbol_type sym);
      int unsigned gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap       = $urandom_range(1, 7);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.action    = act;
      req_payload.symbol_in = sym;
      req_valid             = 1'b1;
      do @(posedge clock); while (!req_ready);
      tracker.absorb_beat(req_payload);
      beats_sent++;
      quiet_tail = (beats_sent >= QUIET_FROM);
      @(negedge clock);
   endtask

   // A codeword: optional clear, data, pad steps, then a parity readout that may be
   // interrupted by fresh data or run past the end of the parity. Long pads and full
   // readouts are only chosen while enough beat budget is left, or when requested.
   task automatic run_codeword(input bit full_read);
      int unsigned n_data;
      int unsigned n_pad;
      int unsigned n_read;
      int unsigned split;
      int unsigned room;
      room = (beats_sent < ITEM_TARGET) ? ITEM_TARGET - beats_sent : 0;
      if ($urandom_range(0, 9) < 7) begin
         offer_beat(ACT_CLEAR, pick_symbol());
      end
      n_data = $urandom_range(1, 24);
      repeat (n_data) offer_beat(ACT_DATA, pick_symbol());
      if (room > 400 && $urandom_range(0, 15) == 0) begin
         n_pad = $urandom_range(40, 160);
      end else begin
         n_pad = $urandom_range(0, 6);
      end
      repeat (n_pad) offer_beat(ACT_PAD, pick_symbol());
      if (full_read || (room > PARITY_SYMBOLS + 200 && $urandom_range(0, 1) == 1)) begin
         n_read = PARITY_SYMBOLS;
      end else begin
         n_read = $urandom_range(1, 40);
      end
      split  = n_read;
      if (n_read > 1 && $urandom_range(0, 3) == 0) begin
         split = $urandom_range(1, n_read - 1);
      end
      repeat (split) offer_beat(ACT_READ, pick_symbol());
      if (split < n_read) begin
         repeat ($urandom_range(1, 3)) offer_beat(ACT_DATA, pick_symbol());
         repeat (n_read - split) offer_beat(ACT_READ, pick_symbol());
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) offer_beat(ACT_READ, pick_symbol());
      end
   endtask

   // Main sequence.
   initial begin
      bit first;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: symbol extremes, every action, reads mixed with feeds and clears.
      offer_beat(ACT_DATA, 12'h000);
      offer_beat(ACT_DATA, 12'hfff);
      offer_beat(ACT_DATA, 12'h001);
      offer_beat(ACT_DATA, 12'h800);
      offer_beat(ACT_DATA, 12'h555);
      offer_beat(ACT_DATA, 12'haaa);
      offer_beat(ACT_PAD, 12'hfff);
      offer_beat(ACT_PAD, 12'h000);
      repeat (4) offer_beat(ACT_READ, 12'h000);
      offer_beat(ACT_DATA, 12'h123);
      repeat (2) offer_beat(ACT_READ, 12'hfff);
      offer_beat(ACT_CLEAR, 12'h000);
      repeat (2) offer_beat(ACT_READ, 12'h000);
      offer_beat(ACT_DATA, 12'hfff);
      offer_beat(ACT_PAD, 12'h000);
      offer_beat(ACT_READ, 12'h000);
      offer_beat(ACT_CLEAR, 12'hfff);

      // Random: mostly whole codewords, some noise beats in between.
      first = 1'b1;
      while (beats_sent < ITEM_TARGET) begin
         if (first || $urandom_range(0, 3) != 0) begin
            run_codeword(first);
         end else begin
            repeat ($urandom_range(1, 16)) begin
               offer_beat(action_type'($urandom_range(0, 3)), pick_symbol());
            end
         end
         first = 1'b0;
      end
      req_valid = 1'b0;

      // Drain, then give the pipeline time to show any extra beat.
      while (tracker.awaited_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.awaited_q.size() != 0) begin
         tracker.fail_count++;
         $display("%0d results never arrived", tracker.awaited_q.size());
      end

      $display("Sent %0d beats: %0d data, %0d pad, %0d read, %0d clear.", beats_sent,
               tracker.action_seen[ACT_DATA], tracker.action_seen[ACT_PAD],
               tracker.action_seen[ACT_READ], tracker.action_seen[ACT_CLEAR]);
      $display("Checked %0d results, %0d of them closing a parity readout; %0d failures.",
               tracker.checked_count, tracker.closing_seen, tracker.fail_count);
      if (tracker.fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
